@@ design/alid_pkg.sv @@
// shared constants, codes and types for the array list insert/delete block
// no dependencies
package alid_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int IDX_OUT_W = 5;
    localparam int CNT_OUT_W = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
    } cmd_ctrl_t;

endpackage

@@ design/alid_front.sv @@
// front end: accepts input transactions, drops unused op codes, converts the value
// to the stored word width and pushes commands to the queue; uses alid_pkg
module alid_front
    import alid_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OP_W-1:0]         op,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    q_full,
    output logic                    q_push,
    output cmd_ctrl_t               q_ctrl,
    output logic [VALUE_WIDTH-1:0]  q_word
);

    assign in_stall   = q_full;
    assign q_push     = in_valid && !q_full && (op != OP_NONE);
    assign q_ctrl.op  = op;
    assign q_ctrl.pos = position;
    assign q_word     = VALUE_WIDTH'(value);

endmodule

@@ design/alid_queue.sv @@
// two-entry command queue between front and back ends
// uses alid_pkg for the command type
module alid_queue
    import alid_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cmd_ctrl_t              push_ctrl,
    input  logic [VALUE_WIDTH-1:0] push_word,
    output logic                   full,
    output logic                   head_valid,
    output cmd_ctrl_t              head_ctrl,
    output logic [VALUE_WIDTH-1:0] head_word,
    input  logic                   pop
);

    localparam int QD    = 2;
    localparam int PTR_W = $clog2(QD);
    localparam int FILL_W = $clog2(QD + 1);

    cmd_ctrl_t              ctrl_mem_reg [QD];
    logic [VALUE_WIDTH-1:0] word_mem_reg [QD];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   do_push, do_pop;

    assign full       = (fill_reg == FILL_W'(QD));
    assign head_valid = (fill_reg != '0);
    assign head_ctrl  = ctrl_mem_reg[rd_ptr_reg];
    assign head_word  = word_mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_mem_reg[wr_ptr_reg] <= push_ctrl;
            word_mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ design/alid_back.sv @@
// back end: entry store, count, delete scan, list streaming and result register
// uses alid_pkg for codes and the command type
module alid_back
    import alid_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  cmd_ctrl_t                   q_ctrl,
    input  logic [VALUE_WIDTH-1:0]      q_word,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [STAT_W-1:0]           status,
    output logic signed [VAL_W-1:0]     entry_value,
    output logic [IDX_OUT_W-1:0]        entry_index,
    output logic [CNT_OUT_W-1:0]        entry_count,
    output logic                        last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] word_reg, word_next;
    logic [VALUE_WIDTH-1:0] entries_reg [DEPTH];
    logic [VALUE_WIDTH-1:0] entries_next [DEPTH];

    logic                   valid_reg;
    logic [STAT_W-1:0]      status_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [IDX_OUT_W-1:0]   index_reg;
    logic [CNT_OUT_W-1:0]   cnt_out_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   emit;
    logic [STAT_W-1:0]      e_status;
    logic signed [VAL_W-1:0] e_value;
    logic [CNT_W-1:0]       e_index;
    logic                   e_last;
    logic [VALUE_WIDTH-1:0] rd_word;
    logic [CMP_W-1:0]       pos_ext, cnt_ext, idx_ext;

    assign out_free = !valid_reg || !out_stall;
    assign rd_word  = entries_reg[idx_reg[IDX_W-1:0]];
    assign pos_ext  = CMP_W'(q_ctrl.pos);
    assign cnt_ext  = CMP_W'(count_reg);
    assign idx_ext  = CMP_W'(idx_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        word_next    = word_reg;
        entries_next = entries_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        e_status     = ST_OK;
        e_value      = '0;
        e_index      = '0;
        e_last       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_ctrl.op)
                        OP_INSERT:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                                if (count_reg == CNT_W'(DEPTH))
                                begin
                                    e_status = ST_FULL;
                                end
                                else if (pos_ext > cnt_ext)
                                begin
                                    e_status = ST_BADPOS;
                                end
                                else
                                begin
                                    e_index    = CNT_W'(pos_ext);
                                    count_next = count_reg + 1'b1;
                                    for (int j = 0; j < DEPTH; j++)
                                    begin
                                        if (CMP_W'(j) == pos_ext)
                                        begin
                                            entries_next[j] = q_word;
                                        end
                                        else if (j > 0 && CMP_W'(j) > pos_ext
                                                 && CMP_W'(j) <= cnt_ext)
                                        begin
                                            entries_next[j] = entries_reg[(j > 0) ? j - 1 : 0];
                                        end
                                    end
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            q_pop      = 1'b1;
                            word_next  = q_word;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        OP_LIST:
                        begin
                            q_pop      = 1'b1;
                            idx_next   = '0;
                            state_next = S_LIST;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_status   = ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                end
                else if (rd_word == word_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_index    = idx_reg;
                        count_next = count_reg - 1'b1;
                        state_next = S_IDLE;
                        for (int j = 0; j < DEPTH - 1; j++)
                        begin
                            if (CMP_W'(j) >= idx_ext && CMP_W'(j + 1) < cnt_ext)
                            begin
                                entries_next[j] = entries_reg[j + 1];
                            end
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (count_reg == '0)
                    begin
                        e_status   = ST_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        e_value  = VAL_W'($signed(rd_word));
                        e_index  = idx_reg;
                        e_last   = (idx_reg + 1'b1 == count_reg);
                        idx_next = idx_reg + 1'b1;
                        if (e_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        entries_reg <= entries_next;
        if (emit)
        begin
            status_reg  <= e_status;
            value_reg   <= e_value;
            index_reg   <= IDX_OUT_W'(e_index);
            cnt_out_reg <= CNT_OUT_W'(count_next);
            last_reg    <= e_last;
        end
    end

    assign out_valid   = valid_reg;
    assign status      = status_reg;
    assign entry_value = value_reg;
    assign entry_index = index_reg;
    assign entry_count = cnt_out_reg;
    assign last        = last_reg;

endmodule

@@ design/array_list_insert_delete.sv @@
// ordered list with insert at position, delete first match and list all
// an insert result passes through the command queue and the result register; a delete
// scans from index 0 up to the match or the count; list and insert results come one per
// cycle while out_stall is low; a delete or list holds the back end until it is done
// reset clears the count, the queue and the result valid flag; entry store and result data stay
module array_list_insert_delete
    import alid_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OP_W-1:0]         op,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0] entry_value,
    output logic [IDX_OUT_W-1:0]    entry_index,
    output logic [CNT_OUT_W-1:0]    entry_count,
    output logic                    last
);

    logic                   q_full;
    logic                   q_push;
    cmd_ctrl_t              push_ctrl;
    logic [VALUE_WIDTH-1:0] push_word;
    logic                   q_valid;
    cmd_ctrl_t              head_ctrl;
    logic [VALUE_WIDTH-1:0] head_word;
    logic                   q_pop;

    alid_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .position (position),
        .value    (value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctrl   (push_ctrl),
        .q_word   (push_word)
    );

    alid_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ctrl  (push_ctrl),
        .push_word  (push_word),
        .full       (q_full),
        .head_valid (q_valid),
        .head_ctrl  (head_ctrl),
        .head_word  (head_word),
        .pop        (q_pop)
    );

    alid_back #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ctrl      (head_ctrl),
        .q_word      (head_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_value (entry_value),
        .entry_index (entry_index),
        .entry_count (entry_count),
        .last        (last)
    );

endmodule

@@ tb/sv/tb_array_list_insert_delete.sv @@
// self-checking testbench for array_list_insert_delete: directed and random list commands
// depends on alid_pkg and the array_list_insert_delete rtl
module tb_array_list_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import alid_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int CMD_TARGET  = 290;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 21;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } list_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value;
        logic [IDX_OUT_W-1:0]    index;
        logic [CNT_OUT_W-1:0]    count;
        logic                    last;
    } list_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    out_valid;
    logic                    out_stall;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] entry_value;
    logic [IDX_OUT_W-1:0]    entry_index;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    last;

    list_cmd_t               pending_cmds[$];
    list_result_t            expected_results[$];
    logic signed [VAL_W-1:0] list_model[$];
    logic signed [VAL_W-1:0] gen_list[$];
    list_result_t            exp_r;
    list_cmd_t               next_cmd;
    logic                    in_fire;
    logic                    calm;
    int                      cyc;
    int                      err_cnt;

    array_list_insert_delete DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_value (entry_value),
        .entry_index (entry_index),
        .entry_count (entry_count),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    assign calm = (cyc >= 1500) && (cyc < 2700);

    function automatic list_result_t make_result(input logic [STAT_W-1:0] st,
                                                 input logic signed [VAL_W-1:0] v,
                                                 input int idx, input logic lst);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.index  = IDX_OUT_W'(idx);
        r.count  = CNT_OUT_W'(list_model.size());
        r.last   = lst;
        return r;
    endfunction

    task automatic predict_list_op(input logic [OP_W-1:0] o, input logic [POS_W-1:0] p,
                                   input logic signed [VAL_W-1:0] v);
        int hits[$];
        int n;
        case (o)
            OP_INSERT:
            begin
                if (list_model.size() >= LIST_DEPTH)
                    expected_results.push_back(make_result(ST_FULL, '0, 0, 1'b1));
                else if (int'(p) > list_model.size())
                    expected_results.push_back(make_result(ST_BADPOS, '0, 0, 1'b1));
                else
                begin
                    list_model.insert(int'(p), v);
                    expected_results.push_back(make_result(ST_OK, '0, int'(p), 1'b1));
                end
            end
            OP_DELETE:
            begin
                hits = list_model.find_first_index(item) with (item == v);
                if (hits.size() == 0)
                    expected_results.push_back(make_result(ST_NOTFOUND, '0, 0, 1'b1));
                else
                begin
                    list_model.delete(hits[0]);
                    expected_results.push_back(make_result(ST_OK, '0, hits[0], 1'b1));
                end
            end
            OP_LIST:
            begin
                n = list_model.size();
                if (n == 0)
                    expected_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                else
                    for (int i = 0; i < n; i++)
                        expected_results.push_back(make_result(ST_OK, list_model[i], i,
                                                               i == n - 1));
            end
            default:
            begin
            end
        endcase
    endtask

    // queues a command and tracks the list contents it will leave behind
    task automatic add_cmd(input logic [OP_W-1:0] o, input int p,
                           input logic signed [VAL_W-1:0] v);
        list_cmd_t c;
        int        hits[$];
        c.op    = o;
        c.pos   = POS_W'(p);
        c.value = v;
        pending_cmds.push_back(c);
        if (o == OP_INSERT && gen_list.size() < LIST_DEPTH && p <= gen_list.size())
            gen_list.insert(p, v);
        else if (o == OP_DELETE)
        begin
            hits = gen_list.find_first_index(item) with (item == v);
            if (hits.size() != 0)
                gen_list.delete(hits[0]);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 32'sh7fffffff;
        else if (r < 6)
            return 32'sh80000000;
        else if (r < 8)
            return '0;
        else if (r < 10)
            return -32'sd1;
        else if (r < 35)
            return VAL_W'($urandom_range(0, 7)) - 32'sd4;
        else
            return $urandom();
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    op       <= next_cmd.op;
                    position <= next_cmd.pos;
                    value    <= next_cmd.value;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cyc     <= cyc + 1;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_list_op(op, position, value);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transaction: status %0d, entry_value %0d", status,
                       entry_value);
                err_cnt++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
                    err_cnt++;
                end
                if (entry_value !== exp_r.value)
                begin
                    $error("entry_value mismatch: expected %0d, actual %0d", exp_r.value,
                           entry_value);
                    err_cnt++;
                end
                if (entry_index !== exp_r.index)
                begin
                    $error("entry_index mismatch: expected %0d, actual %0d", exp_r.index,
                           entry_index);
                    err_cnt++;
                end
                if (entry_count !== exp_r.count)
                begin
                    $error("entry_count mismatch: expected %0d, actual %0d", exp_r.count,
                           entry_count);
                    err_cnt++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", exp_r.last, last);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        wait (cyc >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int n_cmds;
        int mode;
        int ins_pct;
        int del_pct;
        int len;
        int r;
        int rr;
        int sz;
        int p;
        cyc       = 0;
        err_cnt   = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_fire   = 1'b0;
        out_stall = 1'b0;
        op        = OP_INSERT;
        position  = '0;
        value     = '0;

        // directed: empty list cases, extremes, bad positions, ignored op
        add_cmd(OP_LIST, 0, '0);
        add_cmd(OP_DELETE, 0, 32'sd7);
        add_cmd(OP_INSERT, 1, 32'sd9);
        add_cmd(OP_INSERT, 0, 32'sh7fffffff);
        add_cmd(OP_INSERT, 1, 32'sh80000000);
        add_cmd(OP_INSERT, 2, '0);
        add_cmd(OP_INSERT, 0, -32'sd1);
        add_cmd(OP_INSERT, 63, 32'sd5);
        add_cmd(OP_INSERT, 4, 32'sd5);
        add_cmd(OP_LIST, 0, '0);
        add_cmd(OP_NONE, 63, -32'sd1);
        add_cmd(OP_DELETE, 0, 32'sh80000000);
        add_cmd(OP_DELETE, 0, 32'sd123);
        add_cmd(OP_DELETE, 0, -32'sd1);
        add_cmd(OP_INSERT, 1, 32'sh55555555);
        add_cmd(OP_INSERT, 2, 32'shaaaaaaaa);
        add_cmd(OP_INSERT, 0, 32'sd5);
        add_cmd(OP_LIST, 0, '0);
        add_cmd(OP_DELETE, 0, 32'sd5);
        add_cmd(OP_DELETE, 0, 32'sh7fffffff);
        add_cmd(OP_DELETE, 0, 32'shaaaaaaaa);
        add_cmd(OP_DELETE, 0, '0);
        add_cmd(OP_DELETE, 0, 32'sh55555555);
        add_cmd(OP_LIST, 0, '0);

        // fill to capacity, then push on a full list
        for (int i = 0; i < LIST_DEPTH + 2; i++)
            add_cmd(OP_INSERT, $urandom_range(0, gen_list.size()), pick_value());
        add_cmd(OP_INSERT, 63, pick_value());
        add_cmd(OP_LIST, 0, '0);

        n_cmds = 0;
        while (n_cmds < CMD_TARGET)
        begin
            mode = $urandom_range(0, 2);
            if (mode == 0)
            begin
                ins_pct = 75;
                del_pct = 15;
            end
            else if (mode == 1)
            begin
                ins_pct = 15;
                del_pct = 70;
            end
            else
            begin
                ins_pct = 40;
                del_pct = 40;
            end
            len = $urandom_range(10, 40);
            repeat (len)
            begin
                r  = $urandom_range(0, 103);
                sz = gen_list.size();
                if (r >= 100)
                    add_cmd(OP_NONE, $urandom_range(0, 63), $urandom());
                else if (r < ins_pct)
                begin
                    rr = $urandom_range(0, 99);
                    if (rr < 10)
                        p = 0;
                    else if (rr < 20)
                        p = sz;
                    else if (rr < 30)
                        p = $urandom_range(sz + 1, 63);
                    else
                        p = $urandom_range(0, sz);
                    add_cmd(OP_INSERT, p, pick_value());
                    n_cmds++;
                end
                else if (r < ins_pct + del_pct)
                begin
                    if (sz != 0 && $urandom_range(0, 99) < 70)
                        add_cmd(OP_DELETE, $urandom_range(0, 63),
                                gen_list[$urandom_range(0, sz - 1)]);
                    else
                        add_cmd(OP_DELETE, $urandom_range(0, 63), pick_value());
                    n_cmds++;
                end
                else
                begin
                    add_cmd(OP_LIST, $urandom_range(0, 63), $urandom());
                    n_cmds++;
                end
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (err_cnt == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
